// ===== hdl/atrq_pkg.sv =====
// shared constants and types for the agent table radius query unit
package atrq_pkg;

  localparam int CAPACITY   = 32;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SQRT_STEPS = 17;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

  localparam logic [1:0] OP_ENTER  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_LEAVE  = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ALREADY_IN = 2'd1;
  localparam logic [1:0] ST_NOT_INSIDE = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  typedef struct packed {
    logic [15:0] agent;
    logic [15:0] x;
    logic [15:0] y;
  } slot_entry_t;

endpackage

// ===== hdl/agent_table_radius_query_unit.sv =====
// agent table with enter, update, leave and fixed-radius neighbour query
// one item at a time: every operation first sweeps the slot memory once to look up
// the agent (one synchronous read a cycle), then passes a decide state and ends with
// a final result word. a query whose agent is found then sweeps the memory again: a
// free or own slot is only read and skipped, any other slot goes through the read,
// difference, squares, and sum and compare states, and every neighbour found inside the
// radius runs a serial bit-pair square root; from the second neighbour on, a push state
// hands over the previous word. the run time is set by the single memory port and the
// serial square root. words leave through an output register, so a stall on the result
// side only holds the sequencer when the next word is ready
module agent_table_radius_query_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_agent_id,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [16:0] in_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_has_neighbor,
  output logic [15:0] out_neighbor_id,
  output logic [16:0] out_neighbor_distance,
  output logic [15:0] out_out_x,
  output logic [15:0] out_out_y,
  output logic        out_last
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_FIND   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_SREAD  = 10'b0000001000,
    S_SDIFF  = 10'b0000010000,
    S_SSQ    = 10'b0000100000,
    S_SCMP   = 10'b0001000000,
    S_SQRT   = 10'b0010000000,
    S_PUSH   = 10'b0100000000,
    S_FINAL  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory and per-slot occupancy flags
  atrq_pkg::slot_entry_t mem [atrq_pkg::CAPACITY];
  atrq_pkg::slot_entry_t rdata_r;
  logic [atrq_pkg::CAPACITY-1:0] used_r;

  logic                        wr_en;
  logic [atrq_pkg::SLOT_W-1:0] wr_addr;
  atrq_pkg::slot_entry_t       wr_data;
  logic [atrq_pkg::SLOT_W-1:0] rd_addr;
  logic [atrq_pkg::SLOT_W-1:0] rd_slot_r;
  logic                        rd_v_r;

  logic [15:0] entrance_x_r;

  // latched item
  logic [1:0]  op_r;
  logic [15:0] id_r, px_r, py_r;
  logic [16:0] rad_r;
  logic [33:0] r2_r;

  // lookup results
  logic                        found_r;
  logic [atrq_pkg::SLOT_W-1:0] me_r;
  logic [15:0]                 me_x_r, me_y_r;

  logic [atrq_pkg::CNT_W-1:0]  idx_r;
  logic [1:0]                  res_status_r;
  logic [15:0]                 res_x_r;

  // query datapath
  logic [15:0] dx_r, dy_r, nbr_id_r;
  logic [31:0] sqx_r, sqy_r;
  logic [32:0] d2;
  logic [33:0] sq_v_r;
  logic [19:0] sq_rem_r;
  logic [16:0] sq_root_r;
  logic [atrq_pkg::SQRT_CNT_W-1:0] sq_cnt_r;
  logic [19:0] rem_sh, trial;

  // neighbour held back until we know whether it is the last one
  logic        pend_v_r;
  logic [15:0] pend_id_r;
  logic [16:0] pend_dist_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_hn_r;
  logic [15:0] out_id_r;
  logic [16:0] out_dist_r;
  logic [15:0] out_x_r;
  logic        out_last_r;

  logic                        out_free;
  logic                        full;
  logic [atrq_pkg::SLOT_W-1:0] free_slot;
  logic [atrq_pkg::SLOT_W-1:0] idx_slot;
  logic                        idx_end;
  logic                        skip;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign idx_slot = idx_r[atrq_pkg::SLOT_W-1:0];
  assign idx_end  = (idx_r == atrq_pkg::CNT_W'(atrq_pkg::CAPACITY));
  assign skip     = !used_r[idx_slot] || (idx_slot == me_r);
  assign full     = &used_r;
  assign d2       = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign rem_sh   = {sq_rem_r[17:0], sq_v_r[33:32]};
  assign trial    = {1'b0, sq_root_r, 2'b01};

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = atrq_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) free_slot = atrq_pkg::SLOT_W'(i);
    end
  end

  assign rd_addr = idx_slot;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = me_r;
    wr_data = '{agent: id_r, x: px_r, y: py_r};
    if (state_r == S_DECIDE) begin
      if (op_r == atrq_pkg::OP_ENTER && !found_r && !full) begin
        wr_en   = 1'b1;
        wr_addr = free_slot;
        wr_data = '{agent: id_r, x: entrance_x_r, y: 16'd0};
      end else if (op_r == atrq_pkg::OP_UPDATE && found_r) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r   <= mem[rd_addr];
    rd_slot_r <= rd_addr;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_FIND;
      S_FIND:   if (idx_end && !rd_v_r) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (op_r == atrq_pkg::OP_QUERY && found_r) state_nxt = S_SREAD;
        else state_nxt = S_FINAL;
      end
      S_SREAD: begin
        if (idx_end) state_nxt = S_FINAL;
        else if (!skip) state_nxt = S_SDIFF;
      end
      S_SDIFF:  state_nxt = S_SSQ;
      S_SSQ:    state_nxt = S_SCMP;
      S_SCMP:   state_nxt = ({1'b0, d2} < r2_r) ? S_SQRT : S_SREAD;
      S_SQRT: begin
        if (sq_cnt_r == atrq_pkg::SQRT_CNT_W'(atrq_pkg::SQRT_STEPS - 1)) begin
          state_nxt = pend_v_r ? S_PUSH : S_SREAD;
        end
      end
      S_PUSH:   if (out_free) state_nxt = S_SREAD;
      S_FINAL:  if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      entrance_x_r <= '0;
      out_valid_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      rd_v_r       <= 1'b0;
      found_r      <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) entrance_x_r <= cfg_wr_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      rd_v_r <= (state_r == S_FIND) && !idx_end;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= in_operation;
            id_r         <= in_agent_id;
            px_r         <= in_pos_x;
            py_r         <= in_pos_y;
            rad_r        <= in_radius;
            found_r      <= 1'b0;
            pend_v_r     <= 1'b0;
            idx_r        <= '0;
            res_x_r      <= '0;
            res_status_r <= atrq_pkg::ST_OK;
          end
        end
        S_FIND: begin
          r2_r <= 34'(rad_r) * 34'(rad_r);
          if (!idx_end) idx_r <= idx_r + 1'b1;
          // lowest used slot holding the id wins
          if (rd_v_r && !found_r && used_r[rd_slot_r] && rdata_r.agent == id_r) begin
            found_r <= 1'b1;
            me_r    <= rd_slot_r;
            me_x_r  <= rdata_r.x;
            me_y_r  <= rdata_r.y;
          end
        end
        S_DECIDE: begin
          idx_r <= '0;
          unique case (op_r)
            atrq_pkg::OP_ENTER: begin
              if (found_r) res_status_r <= atrq_pkg::ST_ALREADY_IN;
              else if (full) res_status_r <= atrq_pkg::ST_TABLE_FULL;
              else begin
                used_r[free_slot] <= 1'b1;
                res_x_r           <= entrance_x_r;
              end
            end
            atrq_pkg::OP_LEAVE: begin
              if (found_r) used_r[me_r] <= 1'b0;
              else res_status_r <= atrq_pkg::ST_NOT_INSIDE;
            end
            default: begin
              if (!found_r) res_status_r <= atrq_pkg::ST_NOT_INSIDE;
            end
          endcase
        end
        S_SREAD: begin
          if (!idx_end && skip) idx_r <= idx_r + 1'b1;
        end
        S_SDIFF: begin
          dx_r     <= (rdata_r.x >= me_x_r) ? rdata_r.x - me_x_r : me_x_r - rdata_r.x;
          dy_r     <= (rdata_r.y >= me_y_r) ? rdata_r.y - me_y_r : me_y_r - rdata_r.y;
          nbr_id_r <= rdata_r.agent;
        end
        S_SSQ: begin
          sqx_r <= 32'(dx_r) * 32'(dx_r);
          sqy_r <= 32'(dy_r) * 32'(dy_r);
        end
        S_SCMP: begin
          if ({1'b0, d2} < r2_r) begin
            sq_v_r    <= {1'b0, d2};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= '0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SQRT: begin
          // one result bit per cycle from the top bit pair down
          sq_v_r   <= {sq_v_r[31:0], 2'b00};
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (rem_sh >= trial) begin
            sq_rem_r  <= rem_sh - trial;
            sq_root_r <= {sq_root_r[15:0], 1'b1};
          end else begin
            sq_rem_r  <= rem_sh;
            sq_root_r <= {sq_root_r[15:0], 1'b0};
          end
          if (sq_cnt_r == atrq_pkg::SQRT_CNT_W'(atrq_pkg::SQRT_STEPS - 1) && !pend_v_r) begin
            pend_v_r    <= 1'b1;
            pend_id_r   <= nbr_id_r;
            pend_dist_r <= (rem_sh >= trial) ? {sq_root_r[15:0], 1'b1}
                                             : {sq_root_r[15:0], 1'b0};
            idx_r       <= idx_r + 1'b1;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= atrq_pkg::ST_OK;
            out_hn_r     <= 1'b1;
            out_id_r     <= pend_id_r;
            out_dist_r   <= pend_dist_r;
            out_x_r      <= '0;
            out_last_r   <= 1'b0;
            pend_id_r    <= nbr_id_r;
            pend_dist_r  <= sq_root_r;
            idx_r        <= idx_r + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_last_r   <= 1'b1;
            out_status_r <= pend_v_r ? atrq_pkg::ST_OK : res_status_r;
            out_hn_r     <= pend_v_r;
            out_id_r     <= pend_v_r ? pend_id_r : 16'd0;
            out_dist_r   <= pend_v_r ? pend_dist_r : 17'd0;
            out_x_r      <= pend_v_r ? 16'd0 : res_x_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_has_neighbor      = out_hn_r;
  assign out_neighbor_id       = out_id_r;
  assign out_neighbor_distance = out_dist_r;
  assign out_out_x             = out_x_r;
  assign out_out_y             = 16'd0;
  assign out_last              = out_last_r;

endmodule
